// File: design/hmp_pkg.sv
// Shared types and constants for the histogram median block.
// Used by hmp_ctrl, hmp_datapath and histogram_median_pixel; depends on nothing.
package hmp_pkg;

   localparam int DEF_BIN_COUNT = 1024;

   localparam int COUNT_W  = 22;
   localparam int SUM_W    = COUNT_W + 1;
   localparam int MEDIAN_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] MODE_MONO8  = 2'd0;
   localparam logic [1:0] MODE_MONO16 = 2'd1;
   localparam logic [1:0] MODE_COLOR  = 2'd2;

   localparam logic [1:0] SMP_FIRST = 2'd0;
   localparam logic [1:0] SMP_THIRD = 2'd2;

   typedef struct packed {
      logic       load;    // latch the pixel and work out its bins
      logic       rmw_rd;  // issue the read half of a bin increment
      logic [1:0] sel;     // which sample of the pixel
      logic       sweep;   // read and zero one bin, advance the sweep counter
      logic       emit;    // result goes out, clear the sample total
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_end;     // the sweep is at the last bin
      logic color;         // the latched pixel carries three samples
   } dp_status_type;

endpackage

// File: design/hmp_datapath.sv
// Datapath of the histogram median block: bin memory, increment pipeline, median scan.
// Depends on hmp_pkg for the command and status structs and the count widths.
module hmp_datapath #(
   parameter int BIN_COUNT = hmp_pkg::DEF_BIN_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hmp_pkg::dp_cmd_type                 cmd,
   output hmp_pkg::dp_status_type              status,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_pixel_mode,
   input  logic [15:0]                         req_chan_a,
   input  logic [7:0]                          req_chan_b,
   input  logic [7:0]                          req_chan_c,
   output logic signed [hmp_pkg::MEDIAN_W-1:0] rsp_median
);

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BIN_COUNT - 1);

   logic [hmp_pkg::COUNT_W-1:0] bin_mem [BIN_COUNT];

   logic [1:0]                  mode_ff;
   logic [IDX_W-1:0]            bin_ff [3];
   logic                        color_ff;
   logic [IDX_W-1:0]            mono_bin;

   logic [IDX_W-1:0]            rd_addr;
   logic [hmp_pkg::COUNT_W-1:0] rd_data_ff;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [hmp_pkg::COUNT_W-1:0] wr_data;

   logic                        rmw_pend_ff;
   logic [IDX_W-1:0]            pend_addr_ff;
   logic                        fwd_ff;
   logic                        fwd_in;
   logic [hmp_pkg::COUNT_W-1:0] wlast_ff;
   logic [hmp_pkg::COUNT_W-1:0] rmw_src;
   logic [hmp_pkg::COUNT_W-1:0] rmw_new;

   logic [hmp_pkg::COUNT_W-1:0] total_ff;
   logic [hmp_pkg::COUNT_W-2:0] half;

   logic [IDX_W-1:0]            sweep_cnt_ff;
   logic [IDX_W-1:0]            acc_idx_ff;
   logic [hmp_pkg::SUM_W-1:0]   sum_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            med_ff;
   logic                        acc_first;
   logic [hmp_pkg::SUM_W-1:0]   base_sum;
   logic                        base_found;
   logic [hmp_pkg::SUM_W-1:0]   acc_sum;
   logic                        hit;

   // A mono 16-bit sample beyond the top bin lands in the top bin.
   always_comb begin
      if (req_chan_a > 16'(BIN_COUNT - 1)) begin
         mono_bin = LAST_BIN;
      end else begin
         mono_bin = req_chan_a[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hmp_pkg::MODE_MONO8;
      end else if (csr_valid) begin
         mode_ff <= csr_pixel_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         color_ff <= (mode_ff == hmp_pkg::MODE_COLOR);
         bin_ff[1] <= IDX_W'(req_chan_b);
         bin_ff[2] <= IDX_W'(req_chan_c);
         if (mode_ff == hmp_pkg::MODE_MONO16) begin
            bin_ff[0] <= mono_bin;
         end else begin
            bin_ff[0] <= IDX_W'(req_chan_a[7:0]);
         end
      end
   end

   // A read issued right behind a write to the same bin would see the old
   // count, so the freshly written value is forwarded instead.
   assign rmw_src = fwd_ff ? wlast_ff : rd_data_ff;
   assign rmw_new = (rmw_src == hmp_pkg::COUNT_MAX) ? rmw_src : rmw_src + 1'b1;

   assign rd_addr = cmd.sweep ? sweep_cnt_ff : bin_ff[cmd.sel];
   assign wr_en   = rmw_pend_ff | cmd.sweep;
   assign wr_addr = cmd.sweep ? sweep_cnt_ff : pend_addr_ff;
   assign wr_data = cmd.sweep ? '0 : rmw_new;
   assign fwd_in  = cmd.rmw_rd & rmw_pend_ff & (pend_addr_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmw_pend_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         rmw_pend_ff <= cmd.rmw_rd;
         fwd_ff      <= fwd_in;
      end
      pend_addr_ff <= rd_addr;
      if (rmw_pend_ff) begin
         wlast_ff <= rmw_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         total_ff <= '0;
      end else if (rmw_pend_ff && total_ff != hmp_pkg::COUNT_MAX) begin
         total_ff <= total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         if (sweep_cnt_ff == LAST_BIN) begin
            sweep_cnt_ff <= '0;
         end else begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end
      end
   end

   // The scan works on each sweep read in the cycle after it. Bin zero starts a new sum.
   assign half       = total_ff[hmp_pkg::COUNT_W-1:1];
   assign acc_first  = (acc_idx_ff == '0);
   assign base_sum   = acc_first ? '0 : sum_ff;
   assign base_found = acc_first ? 1'b0 : found_ff;
   assign acc_sum    = base_sum + hmp_pkg::SUM_W'(rd_data_ff);
   assign hit        = ~base_found & (acc_sum >= hmp_pkg::SUM_W'(half));

   always_ff @(posedge clock) begin
      acc_idx_ff <= sweep_cnt_ff;
      if (!base_found) begin
         sum_ff <= acc_sum;
      end
      found_ff <= base_found | hit;
      if (hit) begin
         med_ff <= acc_idx_ff;
      end else if (acc_first) begin
         med_ff <= LAST_BIN;
      end
   end

   always_comb begin
      if (half == '0) begin
         rsp_median = '1;
      end else begin
         rsp_median = signed'(hmp_pkg::MEDIAN_W'(med_ff));
      end
   end

   assign status.sweep_end = (sweep_cnt_ff == LAST_BIN);
   assign status.color     = color_ff;

endmodule

// File: design/hmp_ctrl.sv
// Controller of the histogram median block: sequences the bin increments and the scan.
// Depends on hmp_pkg for the command and status structs.
module hmp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_is_last,
   input  hmp_pkg::dp_status_type status,
   output hmp_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_PREP,
      ST_SCAN,
      ST_TAIL,
      ST_EMIT
   } state_type;

   state_type  state_ff;
   logic       busy_ff;
   logic       strobe_ff;
   logic       last_ff;
   logic [1:0] smp_ff;
   logic [1:0] smp_last;

   assign smp_last = status.color ? hmp_pkg::SMP_THIRD : hmp_pkg::SMP_FIRST;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         smp_ff    <= hmp_pkg::SMP_FIRST;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.sweep_end) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_COUNT;
                  busy_ff  <= 1'b1;
                  last_ff  <= req_is_last;
                  smp_ff   <= hmp_pkg::SMP_FIRST;
               end
            end
            ST_COUNT: begin
               if (smp_ff == smp_last) begin
                  // The last increment's write lands in the next cycle.
                  if (last_ff) begin
                     state_ff <= ST_PREP;
                  end else begin
                     state_ff <= ST_IDLE;
                     busy_ff  <= 1'b0;
                  end
               end else begin
                  smp_ff <= smp_ff + 1'b1;
               end
            end
            ST_PREP: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (status.sweep_end) begin
                  state_ff <= ST_TAIL;
               end
            end
            ST_TAIL: begin
               state_ff  <= ST_EMIT;
               strobe_ff <= 1'b1;
            end
            ST_EMIT: begin
               state_ff  <= ST_IDLE;
               strobe_ff <= 1'b0;
               busy_ff   <= 1'b0;
            end
            default: begin
               state_ff  <= ST_IDLE;
               strobe_ff <= 1'b0;
               busy_ff   <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) & start;
      cmd.rmw_rd = (state_ff == ST_COUNT);
      cmd.sel    = smp_ff;
      cmd.sweep  = (state_ff == ST_CLEAR) | (state_ff == ST_SCAN);
      cmd.emit   = (state_ff == ST_EMIT);
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// File: design/histogram_median_pixel.sv
// Top level of the histogram median block: controller plus datapath.
// Depends on hmp_pkg, hmp_ctrl and hmp_datapath.
//
//   channel   handshake                fields
//   req       start, busy              req_chan_a, req_chan_b, req_chan_c, req_is_last
//   rsp       rsp_strobe (one cycle)   rsp_median
//   csr       csr_valid, csr_ready     csr_pixel_mode
//
// A pixel makes one bin memory read-modify-write per sample. The last pixel of a region
// then starts a scan that reads and zeroes every bin once through the memory's single
// read port, then the result is shown for one cycle. After reset a clearing pass
// zeroes the bins while busy is high. The receiver cannot stall, so rsp never holds
// back req.
module histogram_median_pixel #(
   parameter int BIN_COUNT = hmp_pkg::DEF_BIN_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [15:0]                         req_chan_a,
   input  logic [7:0]                          req_chan_b,
   input  logic [7:0]                          req_chan_c,
   input  logic                                req_is_last,
   output logic                                rsp_strobe,
   output logic signed [hmp_pkg::MEDIAN_W-1:0] rsp_median,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_pixel_mode
);

   hmp_pkg::dp_cmd_type    cmd;
   hmp_pkg::dp_status_type status;

   // The mode register takes a transfer in any cycle.
   assign csr_ready = 1'b1;

   hmp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   hmp_datapath #(
      .BIN_COUNT (BIN_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid & csr_ready),
      .csr_pixel_mode (csr_pixel_mode),
      .req_chan_a     (req_chan_a),
      .req_chan_b     (req_chan_b),
      .req_chan_c     (req_chan_c),
      .rsp_median     (rsp_median)
   );

endmodule

// File: dv/tb.sv
// Self-checking testbench for histogram_median_pixel: streams pixel regions in every mode
// and checks each median against a histogram kept alongside the block.
// Depends on hmp_pkg and histogram_median_pixel.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BINS = hmp_pkg::DEF_BIN_COUNT;
   localparam int BIN_W = $clog2(BINS);
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PRINT_CAP = 50;
   localparam int PHASE_ITEMS = 50;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic        last;
   } pixel_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_chan_a = '0;
   logic [7:0]  req_chan_b = '0;
   logic [7:0]  req_chan_c = '0;
   logic        req_is_last = 1'b0;
   logic rsp_strobe;
   logic signed [hmp_pkg::MEDIAN_W-1:0] rsp_median;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_pixel_mode = hmp_pkg::MODE_MONO8;

   pixel_type pixel_queue[$];
   logic signed [hmp_pkg::MEDIAN_W-1:0] median_queue[$];

   // Shadow of the block's histogram and mode.
   logic [hmp_pkg::COUNT_W-1:0] bin_tally [BINS];
   logic [hmp_pkg::COUNT_W-1:0] sample_tally;
   logic [1:0] mode_shadow;

   logic req_fired = 1'b0;
   logic csr_fired = 1'b0;
   int   idle_pct = 0;
   int   mismatches = 0;
   int   cycle_count = 0;

   histogram_median_pixel i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_chan_a     (req_chan_a),
      .req_chan_b     (req_chan_b),
      .req_chan_c     (req_chan_c),
      .req_is_last    (req_is_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_median     (rsp_median),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pixel_mode (csr_pixel_mode)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic void count_bin(input int unsigned bin);
      logic [BIN_W-1:0] idx;
      if (bin >= BINS) begin
         idx = BIN_W'(BINS - 1);
      end else begin
         idx = BIN_W'(bin);
      end
      if (bin_tally[idx] != hmp_pkg::COUNT_MAX) bin_tally[idx]++;
      if (sample_tally != hmp_pkg::COUNT_MAX) sample_tally++;
   endfunction

   function automatic logic signed [hmp_pkg::MEDIAN_W-1:0] scan_median();
      int unsigned half;
      int unsigned running;
      half = 32'(sample_tally >> 1);
      running = 0;
      if (half == 0) return '1;
      for (int k = 0; k < BINS; k++) begin
         running += 32'(bin_tally[BIN_W'(k)]);
         if (running >= half) return hmp_pkg::MEDIAN_W'(k);
      end
      return hmp_pkg::MEDIAN_W'(BINS - 1);
   endfunction

   function automatic void tally_pixel(input pixel_type px);
      case (mode_shadow)
         hmp_pkg::MODE_MONO16: count_bin(32'(px.a));
         hmp_pkg::MODE_COLOR: begin
            count_bin(32'(px.a[7:0]));
            count_bin(32'(px.b));
            count_bin(32'(px.c));
         end
         default: count_bin(32'(px.a[7:0]));
      endcase
      if (px.last) begin
         median_queue.push_back(scan_median());
         foreach (bin_tally[k]) bin_tally[k] = '0;
         sample_tally = '0;
      end
   endfunction

   // Monitor: everything is sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         csr_fired <= 1'b0;
         mode_shadow = hmp_pkg::MODE_MONO8;
         sample_tally = '0;
         foreach (bin_tally[k]) bin_tally[k] = '0;
      end else begin
         req_fired <= (start === 1'b1) && (busy === 1'b0);
         csr_fired <= (csr_valid === 1'b1) && (csr_ready === 1'b1);
         if ((csr_valid === 1'b1) && (csr_ready === 1'b1)) mode_shadow = csr_pixel_mode;
         if ((start === 1'b1) && (busy === 1'b0))
            tally_pixel('{req_chan_a, req_chan_b, req_chan_c, req_is_last});
         if (rsp_strobe !== 1'b0) begin
            if (median_queue.size() == 0) begin
               report_mismatch($sformatf("median %0d with no result pending", rsp_median));
            end else if (rsp_median !== median_queue[0]) begin
               report_mismatch($sformatf("median %0d, predicted %0d",
                                         rsp_median, median_queue[0]));
               void'(median_queue.pop_front());
            end else begin
               void'(median_queue.pop_front());
            end
         end
      end
   end

   // Driver: a pixel stays on the request ports until its transfer.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fired) begin
         if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_chan_a  <= pixel_queue[0].a;
            req_chan_b  <= pixel_queue[0].b;
            req_chan_c  <= pixel_queue[0].c;
            req_is_last <= pixel_queue[0].last;
            start       <= 1'b1;
            void'(pixel_queue.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void push_pixel(input logic [15:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic last);
      pixel_queue.push_back('{a, b, c, last});
   endfunction

   function automatic logic [15:0] pick_extreme16();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h00FF;
         3: return 16'hFF00;
         4: return 16'd1023;
         default: return 16'd1024;
      endcase
   endfunction

   // One region of len pixels; the final one carries is_last when closed is set.
   function automatic void push_region(input int len, input int style, input bit closed);
      logic [15:0] base16;
      logic [7:0]  base8;
      logic [15:0] a;
      logic [7:0]  b;
      logic [7:0]  c;
      base16 = 16'($urandom_range(0, 1008));
      base8 = 8'($urandom_range(0, 240));
      for (int i = 0; i < len; i++) begin
         case (style)
            0: begin
               a = 16'($urandom_range(0, 65535));
               b = 8'($urandom_range(0, 255));
               c = 8'($urandom_range(0, 255));
            end
            1: begin
               a = base16 + 16'($urandom_range(0, 15));
               b = base8 + 8'($urandom_range(0, 15));
               c = base8 + 8'($urandom_range(0, 15));
            end
            default: begin
               a = pick_extreme16();
               b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
         endcase
         push_pixel(a, b, c, closed && (i == len - 1));
      end
   endfunction

   task automatic wait_drained();
      while (pixel_queue.size() != 0 || start || median_queue.size() != 0) @(negedge clock);
   endtask

   // The mode changes only once the block has finished every pixel it took.
   task automatic write_mode(input logic [1:0] mode);
      wait_drained();
      repeat (BINS + 16) @(negedge clock);
      csr_pixel_mode <= mode;
      csr_valid      <= 1'b1;
      do @(negedge clock); while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [1:0] mode_plan [8];
      int idle_plan [8];
      int count;
      int len;
      bit open_end;
      mode_plan = '{hmp_pkg::MODE_MONO8, hmp_pkg::MODE_MONO16, hmp_pkg::MODE_COLOR,
                    MODE_UNUSED, hmp_pkg::MODE_MONO16, hmp_pkg::MODE_COLOR,
                    hmp_pkg::MODE_MONO16, hmp_pkg::MODE_MONO8};
      idle_plan = '{0, 66, 0, 19, 66, 19, 0, 66};
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_mode(hmp_pkg::MODE_MONO8);
      push_pixel(16'hFFFF, 8'h00, 8'h00, 1'b1);
      push_pixel(16'h1234, 8'hFF, 8'hFF, 1'b0);
      push_pixel(16'h00FF, 8'h00, 8'h00, 1'b1);
      push_pixel(16'h0000, 8'h00, 8'h00, 1'b0);
      push_pixel(16'h0000, 8'h00, 8'h00, 1'b0);
      push_pixel(16'h00FF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(16'hFFFF, 8'hFF, 8'hFF, 1'b1);

      // Samples above the top bin saturate into it.
      write_mode(hmp_pkg::MODE_MONO16);
      push_pixel(16'hFFFF, 8'h00, 8'h00, 1'b0);
      push_pixel(16'd1023, 8'h00, 8'h00, 1'b0);
      push_pixel(16'd0, 8'h00, 8'h00, 1'b0);
      push_pixel(16'd1024, 8'h00, 8'h00, 1'b1);
      push_pixel(16'd5, 8'h00, 8'h00, 1'b0);
      push_pixel(16'hFFFF, 8'h00, 8'h00, 1'b1);
      push_pixel(16'h8000, 8'hFF, 8'hFF, 1'b1);

      write_mode(hmp_pkg::MODE_COLOR);
      push_pixel(16'hFF00, 8'hFF, 8'h80, 1'b1);
      push_pixel(16'd200, 8'd100, 8'd50, 1'b0);
      push_pixel(16'hFFFF, 8'hFF, 8'hFF, 1'b1);

      write_mode(MODE_UNUSED);
      push_pixel(16'h0107, 8'hAA, 8'h55, 1'b0);
      push_pixel(16'h0203, 8'h00, 8'h00, 1'b1);

      // One region spread over three modes keeps its earlier counts.
      push_pixel(16'h0310, 8'h00, 8'h00, 1'b0);
      write_mode(hmp_pkg::MODE_MONO16);
      push_pixel(16'd900, 8'h00, 8'h00, 1'b0);
      push_pixel(16'd901, 8'h00, 8'h00, 1'b0);
      write_mode(hmp_pkg::MODE_COLOR);
      push_pixel(16'd1, 8'd2, 8'd3, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         write_mode(mode_plan[ph]);
         idle_pct = idle_plan[ph];
         count = 0;
         while (count < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            open_end = (ph != 7) && (count + len >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
            push_region(len, $urandom_range(0, 2), !open_end);
            count += len;
            // Now and then the sender holds off until every median has come back.
            if ($urandom_range(0, 7) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (BINS + 16) @(negedge clock);
      if (mismatches == 0 && median_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: histogram_median_pixel.f
design/hmp_pkg.sv
design/hmp_datapath.sv
design/hmp_ctrl.sv
design/histogram_median_pixel.sv
dv/tb.sv
